/* sv/bpe_pkg.sv */
// ---------------------------------------------------------------------------
// bpe_pkg
// Shared types and constants for the Bezier point evaluator.
// ---------------------------------------------------------------------------
package bpe_pkg;

  localparam int COORD_W   = 24;
  localparam int T_W       = 16;
  localparam int DEG_W     = 3;
  localparam int START_W   = 8;
  localparam int DEG_RESET = 3;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_EVAL   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [START_W-1:0]        start_index;
    logic [T_W-1:0]            t_fraction;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic                      in_range;
  } out_item_t;

endpackage

/* sv/bpe_ram.sv */
// ---------------------------------------------------------------------------
// bpe_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bpe_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/bpe_lerp.sv */
// ---------------------------------------------------------------------------
// bpe_lerp
// One-coordinate interpolator: a + floor((b - a) * t / 2^16).
// Product is registered; the final add is combinational from those registers.
// ---------------------------------------------------------------------------
module bpe_lerp (
  input  logic                                clk,
  input  logic                                load,
  input  logic signed [bpe_pkg::COORD_W-1:0]  a,
  input  logic signed [bpe_pkg::COORD_W-1:0]  b,
  input  logic [bpe_pkg::T_W-1:0]             t,
  output logic signed [bpe_pkg::COORD_W-1:0]  y
);

  localparam int DIFF_W = bpe_pkg::COORD_W + 1;
  localparam int PROD_W = DIFF_W + bpe_pkg::T_W + 1;
  localparam int SUM_W  = PROD_W - bpe_pkg::T_W;

  logic signed [DIFF_W-1:0]           diff;
  logic signed [PROD_W-1:0]           prod;
  logic signed [PROD_W-1:0]           prod_r;
  logic signed [bpe_pkg::COORD_W-1:0] a_r;
  logic signed [SUM_W-1:0]            sum;

  assign diff = $signed({b[bpe_pkg::COORD_W-1], b}) - $signed({a[bpe_pkg::COORD_W-1], a});
  assign prod = PROD_W'(diff) * PROD_W'($signed({1'b0, t}));

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod;
      a_r    <= a;
    end
  end

  // floor shift by 16 is the upper slice of the product
  assign sum = SUM_W'(a_r) + prod_r[PROD_W-1:bpe_pkg::T_W];
  assign y   = sum[bpe_pkg::COORD_W-1:0];

endmodule

/* sv/bezier_point_eval_top.sv */
// ---------------------------------------------------------------------------
// bezier_point_eval_top
// Control point table with de Casteljau Bezier segment evaluation.
// ---------------------------------------------------------------------------
// Each accepted item is one command. Append (kind 0) stores a point at the
// end of the table, delete (kind 1) drops the last point; both return
// nothing, and an append to a full table or a delete on an empty one is
// dropped. Evaluate (kind 2) takes degree+1 consecutive points from
// start_index and returns one result; if any of them is not stored, in_range
// is 0 and the coordinates are 0. Unknown kinds are dropped. The block holds
// in_ready low while an evaluation runs. An evaluation of degree d first
// streams d+1 points out of the table RAM (one read a cycle, registered read
// data), then runs d*(d+1)/2 interpolations, each as a multiply state and then
// an add-and-write-back state, on a single shared x/y multiplier pair, and
// then posts the result; an out-of-range evaluation goes straight to posting.
// The result sits in an output register, so appends and deletes keep flowing
// while a result waits for out_ready. The user must write the degree register
// through cfg_we/cfg_wdata only while the block is idle; the block itself does
// not enforce this. 0 acts as 1 and values above MAX_DEGREE act as MAX_DEGREE.
// ---------------------------------------------------------------------------
module bezier_point_eval_top #(
  parameter int POINT_CAPACITY = 256,
  parameter int MAX_DEGREE     = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bpe_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bpe_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [bpe_pkg::DEG_W-1:0]     cfg_wdata
);

  localparam int AW     = $clog2(POINT_CAPACITY);
  localparam int CNT_W  = $clog2(POINT_CAPACITY + 1);
  localparam int CMP_W  = ((CNT_W > bpe_pkg::START_W) ? CNT_W : bpe_pkg::START_W) + 1;
  localparam int ASUM_W = ((AW > bpe_pkg::START_W) ? AW : bpe_pkg::START_W) + 1;
  localparam int NW     = MAX_DEGREE + 1;        // work point slots
  localparam int WI_W   = $clog2(NW);
  localparam int DW     = bpe_pkg::DEG_W;
  localparam int PW     = $bits(bpe_pkg::point_t);

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  bpe_pkg::state_t     state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [DW-1:0]       deg_r;
  logic [DW-1:0]       deff_r, deff_nxt;      // clamped degree of this evaluation
  logic [bpe_pkg::START_W-1:0] start_r, start_nxt;
  logic [bpe_pkg::T_W-1:0]     t_r, t_nxt;
  logic [DW-1:0]       ld_r, ld_nxt;          // load sequence counter
  logic [DW-1:0]       lvl_r, lvl_nxt;        // points in current level minus one
  logic [DW-1:0]       step_r, step_nxt;      // interpolation within level
  logic                ok_r, ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  bpe_pkg::out_item_t  out_data_r, out_data_nxt;
  bpe_pkg::point_t     work_r   [NW];
  bpe_pkg::point_t     work_nxt [NW];

  // -------------------------------------------------------------------------
  // Combinational helpers
  // -------------------------------------------------------------------------
  logic                in_xfer;
  logic                is_append, is_delete, is_eval;
  logic [DW-1:0]       deg_clamp;
  logic                eval_ok;
  logic                ld_done;
  logic                last_step;
  logic                out_free;
  logic                lerp_load;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [ASUM_W-1:0]   rd_sum;
  logic [PW-1:0]       ram_rdata;
  bpe_pkg::point_t     rd_point;
  bpe_pkg::point_t     lerp_res;
  bpe_pkg::point_t     sh1 [NW];
  bpe_pkg::point_t     sh2 [NW];
  logic [DW-1:0]       ld_m1, lvl_m1;
  logic [WI_W-1:0]     wr_idx;

  assign in_xfer   = in_valid && in_ready;
  assign is_append = (in_data.kind == bpe_pkg::KIND_APPEND);
  assign is_delete = (in_data.kind == bpe_pkg::KIND_DELETE);
  assign is_eval   = (in_data.kind == bpe_pkg::KIND_EVAL);

  always_comb begin
    deg_clamp = deg_r;
    if (deg_r == '0) begin
      deg_clamp = DW'(1);
    end else if (deg_r > DW'(MAX_DEGREE)) begin
      deg_clamp = DW'(MAX_DEGREE);
    end
  end

  // every point start .. start+d must lie below the count
  assign eval_ok = (CMP_W'(in_data.start_index) + CMP_W'(deg_clamp)) < CMP_W'(count_r);

  assign ld_done   = (ld_r == deff_r + DW'(1));
  assign ld_m1     = ld_r - DW'(1);
  assign lvl_m1    = lvl_r - DW'(1);
  assign last_step = (step_r == lvl_m1);
  assign out_free  = !out_valid_r || out_ready;

  // -------------------------------------------------------------------------
  // Point table
  // -------------------------------------------------------------------------
  assign rd_sum    = ASUM_W'(start_r) + ASUM_W'(ld_r);
  assign ram_raddr = rd_sum[AW-1:0];
  assign ram_waddr = count_r[AW-1:0];
  assign rd_point  = bpe_pkg::point_t'(ram_rdata);

  bpe_ram #(
    .WIDTH (PW),
    .DEPTH (POINT_CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (PW'({in_data.point_x, in_data.point_y})),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // -------------------------------------------------------------------------
  // Shared interpolator pair, operands always work slots 0 and 1
  // -------------------------------------------------------------------------
  bpe_lerp u_lerp_x (
    .clk  (clk),
    .load (lerp_load),
    .a    (work_r[0].x),
    .b    (work_r[1].x),
    .t    (t_r),
    .y    (lerp_res.x)
  );

  bpe_lerp u_lerp_y (
    .clk  (clk),
    .load (lerp_load),
    .a    (work_r[0].y),
    .b    (work_r[1].y),
    .t    (t_r),
    .y    (lerp_res.y)
  );

  // Work slots act as a queue: each step consumes the head, the result goes
  // to the tail; the last step of a level also drops the old last point.
  genvar gj;
  generate
    for (gj = 0; gj < NW; gj++) begin : g_shift
      if (gj + 1 < NW) begin : g_s1
        assign sh1[gj] = work_r[gj+1];
      end else begin : g_s1_end
        assign sh1[gj] = work_r[gj];
      end
      if (gj + 2 < NW) begin : g_s2
        assign sh2[gj] = work_r[gj+2];
      end else begin : g_s2_end
        assign sh2[gj] = work_r[gj];
      end
    end
  endgenerate

  // -------------------------------------------------------------------------
  // Sequencer: next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpe_pkg::ST_IDLE: begin
        if (in_xfer && is_eval) begin
          state_nxt = eval_ok ? bpe_pkg::ST_LOAD : bpe_pkg::ST_FINISH;
        end
      end
      bpe_pkg::ST_LOAD: begin
        if (ld_done) begin
          state_nxt = bpe_pkg::ST_MUL;
        end
      end
      bpe_pkg::ST_MUL: begin
        state_nxt = bpe_pkg::ST_ADD;
      end
      bpe_pkg::ST_ADD: begin
        if (last_step && lvl_r == DW'(1)) begin
          state_nxt = bpe_pkg::ST_FINISH;
        end else begin
          state_nxt = bpe_pkg::ST_MUL;
        end
      end
      bpe_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = bpe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bpe_pkg::ST_IDLE;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Sequencer: control outputs
  // -------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    lerp_load = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    case (state_r)
      bpe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ram_we   = in_xfer && is_append && (count_r < CNT_W'(POINT_CAPACITY));
      end
      bpe_pkg::ST_LOAD: begin
        ram_re = (ld_r <= deff_r);
      end
      bpe_pkg::ST_MUL: begin
        lerp_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Datapath next values
  // -------------------------------------------------------------------------
  always_comb begin
    count_nxt     = count_r;
    deff_nxt      = deff_r;
    start_nxt     = start_r;
    t_nxt         = t_r;
    ld_nxt        = ld_r;
    lvl_nxt       = lvl_r;
    step_nxt      = step_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_idx        = '0;
    for (int j = 0; j < NW; j++) begin
      work_nxt[j] = work_r[j];
    end

    case (state_r)
      bpe_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (is_append && count_r < CNT_W'(POINT_CAPACITY)) begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (is_delete && count_r != '0) begin
            count_nxt = count_r - CNT_W'(1);
          end
          if (is_eval) begin
            deff_nxt  = deg_clamp;
            start_nxt = in_data.start_index;
            t_nxt     = in_data.t_fraction;
            ok_nxt    = eval_ok;
            ld_nxt    = '0;
          end
        end
      end
      bpe_pkg::ST_LOAD: begin
        ld_nxt = ld_r + DW'(1);
        if (ld_r != '0) begin
          wr_idx = ld_m1[WI_W-1:0];
          for (int j = 0; j < NW; j++) begin
            if (WI_W'(j) == wr_idx) begin
              work_nxt[j] = rd_point;
            end
          end
        end
        if (ld_done) begin
          lvl_nxt  = deff_r;
          step_nxt = '0;
        end
      end
      bpe_pkg::ST_ADD: begin
        wr_idx = last_step ? lvl_m1[WI_W-1:0] : lvl_r[WI_W-1:0];
        for (int j = 0; j < NW; j++) begin
          work_nxt[j] = last_step ? sh2[j] : sh1[j];
          if (WI_W'(j) == wr_idx) begin
            work_nxt[j] = lerp_res;
          end
        end
        if (last_step) begin
          lvl_nxt  = lvl_m1;
          step_nxt = '0;
        end else begin
          step_nxt = step_r + DW'(1);
        end
      end
      bpe_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (ok_r) begin
            out_data_nxt.curve_x  = work_r[0].x;
            out_data_nxt.curve_y  = work_r[0].y;
            out_data_nxt.in_range = 1'b1;
          end else begin
            out_data_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpe_pkg::ST_IDLE;
      count_r     <= '0;
      deg_r       <= DW'(bpe_pkg::DEG_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        deg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    deff_r     <= deff_nxt;
    start_r    <= start_nxt;
    t_r        <= t_nxt;
    ld_r       <= ld_nxt;
    lvl_r      <= lvl_nxt;
    step_r     <= step_nxt;
    ok_r       <= ok_nxt;
    out_data_r <= out_data_nxt;
    for (int j = 0; j < NW; j++) begin
      work_r[j] <= work_nxt[j];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
